### design/nsd_pkg.sv
// Shared constants, types and command structures of the nearest segment distance unit.
package nsd_pkg;

  // Coordinate format and derived widths
  localparam int COORD_W     = 16;
  localparam int FRAC_BITS   = 12;
  localparam int DIST_W      = 16;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int MUL_IN_W    = COORD_W + 2;
  localparam int PROD_W      = 2 * MUL_IN_W;
  localparam int DOT_W       = PROD_W + 1;
  localparam int LEN_W       = 2 * DIFF_W;
  localparam int CR_W        = 2 * COORD_W + 2;
  localparam int CRM_W       = CR_W - 1;
  localparam int CRL_W       = CRM_W / 2;
  localparam int CRH_W       = CRM_W - CRL_W;
  localparam int NUM_W       = 2 * CRM_W;
  localparam int ROOT_W      = LEN_W + 2 * DIST_W + 2;
  localparam int BIT_W       = $clog2(DIST_W);
  localparam int STEP_W      = 3;
  localparam int IN_TDATA_W  = 4 * COORD_W;
  localparam int OUT_TDATA_W = DIST_W;
  localparam int CFG_IDX_W   = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_X_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_X_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_Y_LOW  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_Y_HIGH = 2'd3;

  // Window reset values: x in (-1, 1), y in (0, 1)
  localparam logic signed [COORD_W-1:0] WIN_X_LOW_RST  = -(COORD_W'(1) << FRAC_BITS);
  localparam logic signed [COORD_W-1:0] WIN_X_HIGH_RST = COORD_W'(1) << FRAC_BITS;
  localparam logic signed [COORD_W-1:0] WIN_Y_LOW_RST  = '0;
  localparam logic signed [COORD_W-1:0] WIN_Y_HIGH_RST = COORD_W'(1) << FRAC_BITS;

  // Last step of the first multiply sequence (dot, length, cross terms)
  localparam logic [STEP_W-1:0] MUL_SEQ_LAST = 3'd5;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_MUL,
    S_DRAIN,
    S_DECIDE,
    S_SQ,
    S_SQ_DRAIN,
    S_ROOT,
    S_ROOT_WAIT,
    S_FINISH
  } state_t;

  // Multiplier operations; each carries its own accumulate action
  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_FX_CX,
    MUL_FY_CY,
    MUL_CX_CX,
    MUL_CY_CY,
    MUL_FX_EY,
    MUL_FY_EX,
    MUL_FX_FX,
    MUL_FY_FY,
    MUL_EX_EX,
    MUL_EY_EY,
    MUL_CRL_CRL,
    MUL_CRH_CRL,
    MUL_CRH_CRH
  } mul_op_t;

  // Which closest point applies to the segment
  typedef enum logic [1:0] {
    BR_FIRST,
    BR_END,
    BR_CROSS
  } branch_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    load;
    mul_op_t mul_op;
    logic    root_start;
    logic    unit_len;
    logic    update;
    logic    emit;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_window;
    logic last;
    logic dot_le_zero;
    logic dot_ge_len;
    logic root_busy;
    logic out_blocked;
  } dp_status_t;

endpackage

### design/nsd_root.sv
// Bit-serial search for the largest distance d with d*d*len <= num.
module nsd_root import nsd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [LEN_W-1:0]  len,
  output logic              busy,
  output logic [DIST_W-1:0] distance
);

  logic [ROOT_W-1:0] part;     // d*d*len so far
  logic [ROOT_W-1:0] tsh;      // (d*len) << (bit+1)
  logic [ROOT_W-1:0] lsh;      // len << (2*bit)
  logic [NUM_W-1:0]  target;
  logic [BIT_W-1:0]  bitpos;
  logic [ROOT_W-1:0] cand;
  logic              fits;
  logic [ROOT_W-1:0] tsh_next;

  // Try the current bit: (d + 2^b)^2 * len = part + tsh + lsh
  always_comb begin
    cand     = part + tsh + lsh;
    fits     = cand <= {{(ROOT_W-NUM_W){1'b0}}, target};
    tsh_next = fits ? (tsh + (lsh << 1)) : tsh;
  end

  // Step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && bitpos == '0) begin
      busy <= 1'b0;
    end
  end

  // Search registers
  always_ff @(posedge clk) begin
    if (start) begin
      part     <= '0;
      tsh      <= '0;
      lsh      <= {{(ROOT_W-LEN_W){1'b0}}, len} << (2 * (DIST_W - 1));
      target   <= num;
      distance <= '0;
      bitpos   <= BIT_W'(DIST_W - 1);
    end else if (busy) begin
      if (fits) begin
        part     <= cand;
        distance <= distance | (DIST_W'(1) << bitpos);
      end
      tsh    <= tsh_next >> 1;
      lsh    <= lsh >> 2;
      bitpos <= bitpos - BIT_W'(1);
    end
  end

endmodule

### design/nsd_datapath.sv
// Datapath: window registers, item registers, shared multiplier, accumulators, result register.
module nsd_datapath import nsd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  dp_cmd_t               cmd,
  output dp_status_t            status,
  input  logic [IN_TDATA_W-1:0] s_tdata,
  input  logic                  s_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COORD_W-1:0]    cfg_data,
  input  logic                  m_tready,
  output logic                  out_valid,
  output logic [DIST_W-1:0]     out_dist,
  output logic                  out_found
);

  logic signed [COORD_W-1:0]  win_x_low, win_x_high, win_y_low, win_y_high;
  logic signed [COORD_W-1:0]  in_fx, in_fy, in_ex, in_ey;
  logic signed [COORD_W-1:0]  fx, fy, ex, ey;
  logic signed [DIFF_W-1:0]   cx, cy;
  logic                       in_window, in_window_in, last;
  logic signed [MUL_IN_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0]   prod;
  mul_op_t                    prod_op;
  logic signed [DOT_W-1:0]    dot_acc;
  logic [LEN_W-1:0]           len_acc;
  logic signed [CR_W-1:0]     cr_acc;
  logic [CRM_W-1:0]           cr_mag;
  logic [CRL_W-1:0]           cr_lo;
  logic [CRH_W-1:0]           cr_hi;
  logic [NUM_W-1:0]           num_acc;
  logic [NUM_W-1:0]           prod_z;
  logic signed [DOT_W:0]      neg_dot;
  logic signed [DOT_W:0]      len_cmp;
  logic [LEN_W-1:0]           root_len;
  logic                       root_busy;
  logic [DIST_W-1:0]          root_dist;
  logic [DIST_W-1:0]          best;
  logic                       any_acc;

  // Unpack the incoming item
  assign in_fx = s_tdata[COORD_W-1:0];
  assign in_fy = s_tdata[2*COORD_W-1:COORD_W];
  assign in_ex = s_tdata[3*COORD_W-1:2*COORD_W];
  assign in_ey = s_tdata[4*COORD_W-1:3*COORD_W];

  // Both endpoints strictly inside the window
  assign in_window_in = (in_fx > win_x_low) && (in_fx < win_x_high) &&
                        (in_ex > win_x_low) && (in_ex < win_x_high) &&
                        (in_fy > win_y_low) && (in_fy < win_y_high) &&
                        (in_ey > win_y_low) && (in_ey < win_y_high);

  // Window registers
  always_ff @(posedge clk) begin
    if (rst) begin
      win_x_low  <= WIN_X_LOW_RST;
      win_x_high <= WIN_X_HIGH_RST;
      win_y_low  <= WIN_Y_LOW_RST;
      win_y_high <= WIN_Y_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIN_X_LOW:  win_x_low  <= cfg_data;
        CFG_WIN_X_HIGH: win_x_high <= cfg_data;
        CFG_WIN_Y_LOW:  win_y_low  <= cfg_data;
        CFG_WIN_Y_HIGH: win_y_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture the item on transfer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fx        <= in_fx;
      fy        <= in_fy;
      ex        <= in_ex;
      ey        <= in_ey;
      cx        <= DIFF_W'(in_ex) - DIFF_W'(in_fx);
      cy        <= DIFF_W'(in_ey) - DIFF_W'(in_fy);
      in_window <= in_window_in;
      last      <= s_tlast;
    end
  end

  // Split the cross product magnitude for squaring in two halves
  assign cr_mag = cr_acc[CR_W-1] ? CRM_W'(-cr_acc) : CRM_W'(cr_acc);
  assign cr_lo  = cr_mag[CRL_W-1:0];
  assign cr_hi  = cr_mag[CRM_W-1:CRL_W];

  // Select multiplier operands
  always_comb begin
    unique case (cmd.mul_op)
      MUL_FX_CX:   begin mul_a = MUL_IN_W'(fx); mul_b = MUL_IN_W'(cx); end
      MUL_FY_CY:   begin mul_a = MUL_IN_W'(fy); mul_b = MUL_IN_W'(cy); end
      MUL_CX_CX:   begin mul_a = MUL_IN_W'(cx); mul_b = MUL_IN_W'(cx); end
      MUL_CY_CY:   begin mul_a = MUL_IN_W'(cy); mul_b = MUL_IN_W'(cy); end
      MUL_FX_EY:   begin mul_a = MUL_IN_W'(fx); mul_b = MUL_IN_W'(ey); end
      MUL_FY_EX:   begin mul_a = MUL_IN_W'(fy); mul_b = MUL_IN_W'(ex); end
      MUL_FX_FX:   begin mul_a = MUL_IN_W'(fx); mul_b = MUL_IN_W'(fx); end
      MUL_FY_FY:   begin mul_a = MUL_IN_W'(fy); mul_b = MUL_IN_W'(fy); end
      MUL_EX_EX:   begin mul_a = MUL_IN_W'(ex); mul_b = MUL_IN_W'(ex); end
      MUL_EY_EY:   begin mul_a = MUL_IN_W'(ey); mul_b = MUL_IN_W'(ey); end
      MUL_CRL_CRL: begin
        mul_a = {{(MUL_IN_W-CRL_W){1'b0}}, cr_lo};
        mul_b = {{(MUL_IN_W-CRL_W){1'b0}}, cr_lo};
      end
      MUL_CRH_CRL: begin
        mul_a = {{(MUL_IN_W-CRH_W){1'b0}}, cr_hi};
        mul_b = {{(MUL_IN_W-CRL_W){1'b0}}, cr_lo};
      end
      MUL_CRH_CRH: begin
        mul_a = {{(MUL_IN_W-CRH_W){1'b0}}, cr_hi};
        mul_b = {{(MUL_IN_W-CRH_W){1'b0}}, cr_hi};
      end
      default:     begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Shared multiplier, product registered with its operation tag
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_op <= MUL_NONE;
    end else begin
      prod_op <= cmd.mul_op;
    end
  end

  assign prod_z = {{(NUM_W-PROD_W){1'b0}}, prod};

  // Accumulate the registered product as its operation directs
  always_ff @(posedge clk) begin
    unique case (prod_op)
      MUL_FX_CX:   dot_acc <= {prod[PROD_W-1], prod};
      MUL_FY_CY:   dot_acc <= dot_acc + {prod[PROD_W-1], prod};
      MUL_CX_CX:   len_acc <= prod[LEN_W-1:0];
      MUL_CY_CY:   len_acc <= len_acc + prod[LEN_W-1:0];
      MUL_FX_EY:   cr_acc  <= prod[CR_W-1:0];
      MUL_FY_EX:   cr_acc  <= cr_acc - prod[CR_W-1:0];
      MUL_FX_FX,
      MUL_EX_EX,
      MUL_CRL_CRL: num_acc <= prod_z;
      MUL_FY_FY,
      MUL_EY_EY:   num_acc <= num_acc + prod_z;
      MUL_CRH_CRL: num_acc <= num_acc + (prod_z << (CRL_W + 1));
      MUL_CRH_CRH: num_acc <= num_acc + (prod_z << (2 * CRL_W));
      default: ;
    endcase
  end

  // Projection tests: dot = -dot_acc
  assign neg_dot = -{dot_acc[DOT_W-1], dot_acc};
  assign len_cmp = {{(DOT_W+1-LEN_W){1'b0}}, len_acc};

  // Root search, with a unit length for the endpoint cases
  assign root_len = cmd.unit_len ? LEN_W'(1) : len_acc;

  nsd_root u_root (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.root_start),
    .num      (num_acc),
    .len      (root_len),
    .busy     (root_busy),
    .distance (root_dist)
  );

  // Running minimum over the frame; clear when the result is loaded into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      best    <= '1;
      any_acc <= 1'b0;
    end else if (cmd.emit) begin
      best    <= '1;
      any_acc <= 1'b0;
    end else if (cmd.update) begin
      any_acc <= 1'b1;
      if (root_dist < best) begin
        best <= root_dist;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_dist  <= best;
      out_found <= any_acc;
    end
  end

  // Status to the controller
  always_comb begin
    status.in_window   = in_window;
    status.last        = last;
    status.dot_le_zero = !dot_acc[DOT_W-1];
    status.dot_ge_len  = neg_dot >= len_cmp;
    status.root_busy   = root_busy;
    status.out_blocked = out_valid && !m_tready;
  end

endmodule

### design/nsd_ctrl.sv
// Controller state machine: sequences the multiplier, root search and result transfer.
module nsd_ctrl import nsd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t            state, state_next;
  logic [STEP_W-1:0] step, step_next;
  branch_t           branch, branch_next;
  logic              sq_last;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      step   <= '0;
      branch <= BR_FIRST;
    end else begin
      state  <= state_next;
      step   <= step_next;
      branch <= branch_next;
    end
  end

  assign sq_last = (branch == BR_CROSS) ? (step == STEP_W'(2)) : (step == STEP_W'(1));

  // Next state and commands
  always_comb begin
    state_next  = state;
    step_next   = step;
    branch_next = branch;
    s_tready    = 1'b0;
    cmd         = '0;
    cmd.mul_op  = MUL_NONE;

    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end

      // Rejected segments go straight to the frame check
      S_CHECK: begin
        step_next  = '0;
        state_next = status.in_window ? S_MUL : S_FINISH;
      end

      // Dot, squared length and cross product terms
      S_MUL: begin
        unique case (step)
          3'd0:    cmd.mul_op = MUL_FX_CX;
          3'd1:    cmd.mul_op = MUL_FY_CY;
          3'd2:    cmd.mul_op = MUL_CX_CX;
          3'd3:    cmd.mul_op = MUL_CY_CY;
          3'd4:    cmd.mul_op = MUL_FX_EY;
          3'd5:    cmd.mul_op = MUL_FY_EX;
          default: cmd.mul_op = MUL_NONE;
        endcase
        if (step == MUL_SEQ_LAST) begin
          step_next  = '0;
          state_next = S_DRAIN;
        end else begin
          step_next = step + STEP_W'(1);
        end
      end

      // Let the last product land
      S_DRAIN: begin
        state_next = S_DECIDE;
      end

      // Pick the closest point: first point, end point, or interior
      S_DECIDE: begin
        priority if (status.dot_le_zero) begin
          branch_next = BR_FIRST;
        end else if (status.dot_ge_len) begin
          branch_next = BR_END;
        end else begin
          branch_next = BR_CROSS;
        end
        step_next  = '0;
        state_next = S_SQ;
      end

      // Build the value under the root
      S_SQ: begin
        unique case (branch)
          BR_FIRST: cmd.mul_op = (step == '0) ? MUL_FX_FX : MUL_FY_FY;
          BR_END:   cmd.mul_op = (step == '0) ? MUL_EX_EX : MUL_EY_EY;
          BR_CROSS: begin
            unique case (step)
              3'd0:    cmd.mul_op = MUL_CRL_CRL;
              3'd1:    cmd.mul_op = MUL_CRH_CRL;
              default: cmd.mul_op = MUL_CRH_CRH;
            endcase
          end
          default:  cmd.mul_op = MUL_NONE;
        endcase
        if (sq_last) begin
          step_next  = '0;
          state_next = S_SQ_DRAIN;
        end else begin
          step_next = step + STEP_W'(1);
        end
      end

      S_SQ_DRAIN: begin
        state_next = S_ROOT;
      end

      S_ROOT: begin
        cmd.root_start = 1'b1;
        cmd.unit_len   = (branch != BR_CROSS);
        state_next     = S_ROOT_WAIT;
      end

      // Fold the distance into the running minimum once the search ends
      S_ROOT_WAIT: begin
        if (!status.root_busy) begin
          cmd.update = 1'b1;
          state_next = S_FINISH;
        end
      end

      // On the last item of a frame, hold until the result register is free
      S_FINISH: begin
        if (!status.last) begin
          state_next = S_IDLE;
        end else if (!status.out_blocked) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### design/nearest_segment_distance_unit.sv
// Top level of the nearest segment distance unit: controller, datapath and port checks.
//
// Segments arrive on the slave stream, one per transfer, as four signed Q4.12
// endpoint coordinates; s_tlast marks the last segment of a frame. A segment
// counts only when both endpoints lie strictly inside the window held in the
// four configuration registers (written through cfg_we / cfg_index / cfg_data).
// After the last segment of a frame one result leaves on the master stream:
// the smallest distance to the origin (unsigned Q4.12) in m_tdata and the
// found flag in m_tuser; the running minimum then clears.
// Each segment takes one shared 18x18 multiplier through up to nine products
// and a sixteen-step bit-serial root search; s_tready returns only after
// an accepted segment is done, and a rejected one skips both. The result is
// registered when the last segment of a frame finishes. A result waits in its
// output register while the next segments are taken; only a second result is
// held back until m_tready.
// Synchronous reset loads the default window (x in (-1,1), y in (0,1)),
// clears the running minimum and empties the output register.
module nearest_segment_distance_unit import nsd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // first_x, first_y, end_x, end_y
  input  logic                   s_tlast,   // frame_end
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // min_distance
  output logic                   m_tuser,   // found
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [COORD_W-1:0]     cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  nsd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  nsd_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tready  (m_tready),
    .out_valid (m_tvalid),
    .out_dist  (m_tdata),
    .out_found (m_tuser)
  );

`ifndef SYNTHESIS
  // One segment at a time: no transfer in the cycle after a transfer
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("segment accepted while the previous one is in work");

  // A result never overwrites one that is still waiting
  assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !(m_tvalid && !m_tready))
    else $error("result register overwritten before transfer");

  // An empty frame reports the maximum distance
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == '1))
    else $error("frame without a segment reports a finite distance");

  // The root search is never restarted while running
  assert property (@(posedge clk) disable iff (rst)
    cmd.root_start |-> !status.root_busy)
    else $error("root search restarted while busy");
`endif

endmodule
